/* hw/rtl/psg_pkg.sv */
// Shared types, widths and constants of the programmable sound generator.
`timescale 1ns / 1ps
`default_nettype none
package psg_pkg;

  // Item and register field widths.
  localparam int OP_W          = 2;
  localparam int BYTE_W        = 8;
  localparam int TABLE_IDX_W   = 4;
  localparam int TABLE_VALUE_W = 13;
  localparam int SAMPLE_W      = 15;
  localparam int VOL_W         = 7;

  // Channel layout: three tone channels, then the noise channel.
  localparam int NUM_TONE    = 3;
  localparam int NUM_CH      = 4;
  localparam int CH_W        = 2;
  localparam int NOISE_CH    = 3;
  localparam int PERIOD_W    = 10;
  localparam int ATTEN_W     = 4;
  localparam int TABLE_DEPTH = 16;
  localparam int LFSR_W      = 16;
  localparam int LATCH_W     = 3;
  localparam int MODE_W      = 3;

  localparam int DEFAULT_AMPLITUDE_BITS = 13;

  // Reset and reload values.
  localparam logic [LFSR_W-1:0]   NOISE_SEED    = 16'h8000;
  localparam logic [PERIOD_W-1:0] NOISE_RELOAD0 = 10'h010;
  localparam logic [PERIOD_W-1:0] NOISE_RELOAD1 = 10'h020;
  localparam logic [PERIOD_W-1:0] NOISE_RELOAD2 = 10'h040;
  localparam logic [ATTEN_W-1:0]  ATTEN_RESET   = 4'hF;
  localparam logic [VOL_W-1:0]    VOL_MAX       = 7'd100;
  localparam logic [VOL_W-1:0]    VOL_RESET     = 7'd100;

  // Division by 100 as a multiply by ceil(2^26 / 100) and a shift; exact for
  // every dividend below 2^26 / 36, which covers the largest channel product.
  localparam int                  RECIP_W    = 20;
  localparam int                  DIV_SHIFT  = 26;
  localparam logic [RECIP_W-1:0]  DIV_RECIP  = 20'd671089;

  // Item operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_TICK        = 2'd0,
    OP_REG_WRITE   = 2'd1,
    OP_TABLE_LOAD  = 2'd2
  } op_t;

  // Noise reload selection codes (low bits of the noise mode).
  typedef enum logic [1:0] {
    NRATE_16  = 2'd0,
    NRATE_32  = 2'd1,
    NRATE_64  = 2'd2,
    NRATE_T2  = 2'd3
  } noise_rate_t;

  // Volume register write that needs a new amplitude from the table.
  typedef struct packed {
    logic               en;
    logic [CH_W-1:0]    ch;
    logic [ATTEN_W-1:0] code;
  } vol_cmd_t;

endpackage
`default_nettype wire

/* hw/rtl/psg_if.sv */
// Valid/ready channel interfaces for the input items and the sample results.
`timescale 1ns / 1ps
`default_nettype none
interface psg_in_if;
  import psg_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic [BYTE_W-1:0]        data_byte;
  logic [TABLE_IDX_W-1:0]   table_index;
  logic [TABLE_VALUE_W-1:0] table_value;

  modport source (output valid, op, data_byte, table_index, table_value, input ready);
  modport sink   (input valid, op, data_byte, table_index, table_value, output ready);
endinterface

interface psg_out_if;
  import psg_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, sample, input ready);
  modport sink   (input valid, sample, output ready);
endinterface
`default_nettype wire

/* hw/rtl/sn76489_psg_core_unit.sv */
// Top level of the four-channel programmable sound generator.
`timescale 1ns / 1ps
`default_nettype none
// Four-channel sound generator (three square-wave tones, one noise channel
// with a 16-bit shift register). Each item is a tick, a latch/data register
// byte or an amplitude table load; only a tick returns a result, the mixed
// sample of all four channels scaled by cfg_wdata percent (values above 100
// act as 100). One item is accepted every clock cycle unless the output
// side stalls the pipeline; a tick's sample passes through the input
// register, the level register, the channel scaling multiply, the multiply
// that divides by 100, and the final sum register. The output register lets
// new items enter while a sample waits. The amplitude table reads as zero
// until entries are loaded, so the output is silent after reset. The volume
// register may only be written while no item is in flight.
module sn76489_psg_core_unit #(
  parameter int AMPLITUDE_BITS = psg_pkg::DEFAULT_AMPLITUDE_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  psg_in_if.sink                         in_port,
  psg_out_if.source                      out_port,
  input  wire logic                      cfg_we,
  input  wire logic [psg_pkg::VOL_W-1:0] cfg_wdata
);
  import psg_pkg::*;

  logic                     in_v_r;
  logic [OP_W-1:0]          in_op_r;
  logic [BYTE_W-1:0]        in_byte_r;
  logic [TABLE_IDX_W-1:0]   in_idx_r;
  logic [TABLE_VALUE_W-1:0] in_val_r;
  logic [VOL_W-1:0]         volume_r;

  logic                                   proc;
  logic                                   s2_free;
  logic                                   tick_v;
  logic [NUM_CH-1:0]                      level;
  logic [NUM_CH-1:0][ATTEN_W-1:0]         atten;
  vol_cmd_t                               vol_cmd;
  logic [NUM_CH-1:0][AMPLITUDE_BITS-1:0]  amp;

  // The registered item is worked on once the mixer can take a tick.
  assign proc           = in_v_r && s2_free;
  assign tick_v         = proc && (in_op_r == OP_TICK);
  assign in_port.ready  = !in_v_r || proc;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_port.ready) begin
      in_v_r <= in_port.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_port.ready && in_port.valid) begin
      in_op_r   <= in_port.op;
      in_byte_r <= in_port.data_byte;
      in_idx_r  <= in_port.table_index;
      in_val_r  <= in_port.table_value;
    end
  end

  // Global volume register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volume_r <= VOL_RESET;
    end else if (cfg_we) begin
      volume_r <= cfg_wdata;
    end
  end

  psg_chan u_chan (
    .clk       (clk),
    .rst_n     (rst_n),
    .proc      (proc),
    .op        (in_op_r),
    .data_byte (in_byte_r),
    .level_out (level),
    .atten     (atten),
    .vol_cmd   (vol_cmd)
  );

  psg_amp #(
    .AMP_BITS (AMPLITUDE_BITS)
  ) u_amp (
    .clk         (clk),
    .rst_n       (rst_n),
    .proc        (proc),
    .op          (in_op_r),
    .table_index (in_idx_r),
    .table_value (in_val_r),
    .vol_cmd     (vol_cmd),
    .atten       (atten),
    .amp         (amp)
  );

  psg_mix #(
    .AMP_BITS (AMPLITUDE_BITS)
  ) u_mix (
    .clk           (clk),
    .rst_n         (rst_n),
    .tick_v        (tick_v),
    .tick_level    (level),
    .amp           (amp),
    .global_volume (volume_r),
    .s2_free       (s2_free),
    .out_port      (out_port)
  );

endmodule
`default_nettype wire

/* hw/rtl/psg_chan.sv */
// Channel state: register byte decoding, tone timers and the noise shift register.
`timescale 1ns / 1ps
`default_nettype none
module psg_chan (
  input  wire logic                                       clk,
  input  wire logic                                       rst_n,
  input  wire logic                                       proc,
  input  wire logic [psg_pkg::OP_W-1:0]                   op,
  input  wire logic [psg_pkg::BYTE_W-1:0]                 data_byte,
  output      logic [psg_pkg::NUM_CH-1:0]                 level_out,
  output      logic [psg_pkg::NUM_CH-1:0][psg_pkg::ATTEN_W-1:0] atten,
  output      psg_pkg::vol_cmd_t                          vol_cmd
);
  import psg_pkg::*;

  logic [NUM_TONE-1:0][PERIOD_W-1:0] period_r, period_nxt;
  logic [NUM_TONE-1:0][PERIOD_W-1:0] timer_r, timer_nxt;
  logic [NUM_CH-1:0]                 level_r, level_nxt;
  logic [NUM_CH-1:0][ATTEN_W-1:0]    atten_r, atten_nxt;
  logic [PERIOD_W-1:0]               ntimer_r, ntimer_nxt;
  logic [LFSR_W-1:0]                 lfsr_r, lfsr_nxt;
  logic                              phase_r, phase_nxt;
  logic [MODE_W-1:0]                 mode_r, mode_nxt;
  logic [LATCH_W-1:0]                latch_r, latch_nxt;

  logic               is_tick;
  logic               is_wr;
  logic               is_latch;
  logic [LATCH_W-1:0] latch_sel;
  logic [CH_W-1:0]    reg_ch;
  logic               reg_vol;
  logic               fb;

  assign is_tick   = proc && (op == OP_TICK);
  assign is_wr     = proc && (op == OP_REG_WRITE);
  assign is_latch  = data_byte[BYTE_W-1];
  assign latch_sel = is_latch ? data_byte[6:4] : latch_r;
  assign reg_ch    = latch_sel[LATCH_W-1:1];
  assign reg_vol   = latch_sel[0];
  assign fb        = lfsr_r[0] ^ (mode_r[2] & lfsr_r[3]);

  // Next state for a register write or a tick.
  always_comb begin
    period_nxt = period_r;
    timer_nxt  = timer_r;
    level_nxt  = level_r;
    atten_nxt  = atten_r;
    ntimer_nxt = ntimer_r;
    lfsr_nxt   = lfsr_r;
    phase_nxt  = phase_r;
    mode_nxt   = mode_r;
    latch_nxt  = latch_r;

    if (is_wr) begin
      latch_nxt = latch_sel;
      if (reg_vol) begin
        atten_nxt[reg_ch] = data_byte[ATTEN_W-1:0];
      end else if (reg_ch == CH_W'(NOISE_CH)) begin
        // Noise control restarts the shift register.
        mode_nxt = data_byte[MODE_W-1:0];
        lfsr_nxt = NOISE_SEED;
      end else if (is_latch) begin
        period_nxt[reg_ch][3:0] = data_byte[3:0];
      end else begin
        period_nxt[reg_ch][PERIOD_W-1:4] = data_byte[5:0];
      end
    end

    if (is_tick) begin
      // Tone channels toggle when the timer is zero or reaches zero.
      for (int i = 0; i < NUM_TONE; i++) begin
        if (timer_r[i] <= PERIOD_W'(1)) begin
          level_nxt[i] = ~level_r[i];
          timer_nxt[i] = period_r[i];
        end else begin
          timer_nxt[i] = timer_r[i] - PERIOD_W'(1);
        end
      end

      // Noise timer; the register shifts on every second expiry.
      if (ntimer_r <= PERIOD_W'(1)) begin
        phase_nxt = ~phase_r;
        case (noise_rate_t'(mode_r[1:0]))
          NRATE_16: ntimer_nxt = NOISE_RELOAD0;
          NRATE_32: ntimer_nxt = NOISE_RELOAD1;
          NRATE_64: ntimer_nxt = NOISE_RELOAD2;
          NRATE_T2: ntimer_nxt = period_r[NUM_TONE-1];
          default:  ntimer_nxt = period_r[NUM_TONE-1];
        endcase
        if (phase_nxt) begin
          lfsr_nxt            = {fb, lfsr_r[LFSR_W-1:1]};
          level_nxt[NOISE_CH] = lfsr_r[1];
        end
      end else begin
        ntimer_nxt = ntimer_r - PERIOD_W'(1);
      end
    end
  end

  // Channel state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= '0;
      timer_r  <= '0;
      level_r  <= '0;
      atten_r  <= {NUM_CH{ATTEN_RESET}};
      ntimer_r <= '0;
      lfsr_r   <= NOISE_SEED;
      phase_r  <= 1'b0;
      mode_r   <= '0;
      latch_r  <= '0;
    end else begin
      period_r <= period_nxt;
      timer_r  <= timer_nxt;
      level_r  <= level_nxt;
      atten_r  <= atten_nxt;
      ntimer_r <= ntimer_nxt;
      lfsr_r   <= lfsr_nxt;
      phase_r  <= phase_nxt;
      mode_r   <= mode_nxt;
      latch_r  <= latch_nxt;
    end
  end

  assign level_out    = level_nxt;
  assign atten        = atten_r;
  assign vol_cmd.en   = is_wr && reg_vol;
  assign vol_cmd.ch   = reg_ch;
  assign vol_cmd.code = data_byte[ATTEN_W-1:0];

endmodule
`default_nettype wire

/* hw/rtl/psg_amp.sv */
// Amplitude table memory and the current amplitude of each channel.
`timescale 1ns / 1ps
`default_nettype none
module psg_amp #(
  parameter int AMP_BITS = psg_pkg::DEFAULT_AMPLITUDE_BITS
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst_n,
  input  wire logic                                         proc,
  input  wire logic [psg_pkg::OP_W-1:0]                     op,
  input  wire logic [psg_pkg::TABLE_IDX_W-1:0]              table_index,
  input  wire logic [psg_pkg::TABLE_VALUE_W-1:0]            table_value,
  input  wire psg_pkg::vol_cmd_t                            vol_cmd,
  input  wire logic [psg_pkg::NUM_CH-1:0][psg_pkg::ATTEN_W-1:0] atten,
  output      logic [psg_pkg::NUM_CH-1:0][AMP_BITS-1:0]     amp
);
  import psg_pkg::*;

  logic [AMP_BITS-1:0]               mem_r [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]            valid_r;
  logic [AMP_BITS-1:0]               rd_data_r;
  logic                              rd_valid_r;
  logic                              pend_r;
  logic [CH_W-1:0]                   pend_ch_r;
  logic [NUM_CH-1:0][AMP_BITS-1:0]   amp_r, amp_nxt;

  logic                load;
  logic [AMP_BITS-1:0] load_val;

  assign load     = proc && (op == OP_TABLE_LOAD);
  assign load_val = table_value[AMP_BITS-1:0];

  // Table memory: one write port for loads, one read port for volume writes.
  always_ff @(posedge clk) begin
    if (load) begin
      mem_r[table_index] <= load_val;
    end
    if (vol_cmd.en) begin
      rd_data_r  <= mem_r[vol_cmd.code];
      rd_valid_r <= valid_r[vol_cmd.code];
      pend_ch_r  <= vol_cmd.ch;
    end
  end

  // Entries never loaded read as silent.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      if (load) begin
        valid_r[table_index] <= 1'b1;
      end
      pend_r <= vol_cmd.en;
    end
  end

  // A load updates every channel that uses its code; otherwise a pending
  // table read lands in the channel that asked for it.
  always_comb begin
    amp_nxt = amp_r;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (load && (atten[ch] == table_index)) begin
        amp_nxt[ch] = load_val;
      end else if (pend_r && (pend_ch_r == CH_W'(ch))) begin
        amp_nxt[ch] = rd_valid_r ? rd_data_r : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_r <= '0;
    end else begin
      amp_r <= amp_nxt;
    end
  end

  assign amp = amp_r;

endmodule
`default_nettype wire

/* hw/rtl/psg_mix.sv */
// Mixing pipeline: channel scaling, division by 100, summing and output register.
`timescale 1ns / 1ps
`default_nettype none
module psg_mix #(
  parameter int AMP_BITS = psg_pkg::DEFAULT_AMPLITUDE_BITS
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     tick_v,
  input  wire logic [psg_pkg::NUM_CH-1:0]               tick_level,
  input  wire logic [psg_pkg::NUM_CH-1:0][AMP_BITS-1:0] amp,
  input  wire logic [psg_pkg::VOL_W-1:0]                global_volume,
  output      logic                                     s2_free,
  psg_out_if.source                                     out_port
);
  import psg_pkg::*;

  localparam int PROD_W = AMP_BITS + VOL_W;
  localparam int FULL_W = PROD_W + RECIP_W;
  localparam int SUM_W  = AMP_BITS + 2;

  logic                             s2_v_r;
  logic [NUM_CH-1:0]                s2_level_r;
  logic                             s3_v_r;
  logic [NUM_CH-1:0][PROD_W-1:0]    prod_r, prod_nxt;
  logic                             s4_v_r;
  logic [NUM_CH-1:0][AMP_BITS-1:0]  quot_r, quot_nxt;
  logic                             out_v_r;
  logic [SAMPLE_W-1:0]              sample_r, sample_nxt;

  logic               out_free, s4_free, s3_free;
  logic [VOL_W-1:0]   vol_sat;
  logic [FULL_W-1:0]  full [NUM_CH];
  logic [SUM_W-1:0]   sum;

  // A stage takes a new item when it is empty or its item moves on.
  assign out_free = !out_v_r || out_port.ready;
  assign s4_free  = !s4_v_r || out_free;
  assign s3_free  = !s3_v_r || s4_free;
  assign s2_free  = !s2_v_r || s3_free;

  assign vol_sat = (global_volume > VOL_MAX) ? VOL_MAX : global_volume;

  // Scaled channel amplitudes, then quotients by 100, then their sum.
  always_comb begin
    sum = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      prod_nxt[ch] = s2_level_r[ch] ? PROD_W'(amp[ch]) * PROD_W'(vol_sat) : '0;
      full[ch]     = FULL_W'(prod_r[ch]) * FULL_W'(DIV_RECIP);
      quot_nxt[ch] = full[ch][DIV_SHIFT +: AMP_BITS];
      sum          = sum + SUM_W'(quot_r[ch]);
    end
    sample_nxt = SAMPLE_W'(sum);
  end

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s2_free) begin
        s2_v_r <= tick_v;
      end
      if (s3_free) begin
        s3_v_r <= s2_v_r;
      end
      if (s4_free) begin
        s4_v_r <= s3_v_r;
      end
      if (out_free) begin
        out_v_r <= s4_v_r;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (s2_free) begin
      s2_level_r <= tick_level;
    end
    if (s3_free) begin
      prod_r <= prod_nxt;
    end
    if (s4_free) begin
      quot_r <= quot_nxt;
    end
    if (out_free) begin
      sample_r <= sample_nxt;
    end
  end

  assign out_port.valid  = out_v_r;
  assign out_port.sample = sample_r;

endmodule
`default_nettype wire

/* sim/sn76489_psg_core_unit_tb.sv */
// Testbench for the sound generator core: directed and random items checked against a predictor.
`timescale 1ns / 1ps
module sn76489_psg_core_unit_tb;
  import psg_pkg::*;

  localparam int AMP_BITS = DEFAULT_AMPLITUDE_BITS;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  // Low bit of a latched register number: period/control or attenuation.
  localparam logic SEL_PERIOD = 1'b0;
  localparam logic SEL_ATTEN  = 1'b1;
  localparam logic [CH_W-1:0] NOISE_SEL = CH_W'(NOISE_CH);
  localparam int PIPE_DRAIN   = 8;
  localparam int HOLD_CYCLES  = 80;
  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 800;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [VOL_W-1:0]   cfg_wdata;

  psg_in_if  in_ch ();
  psg_out_if out_ch ();

  sn76489_psg_core_unit #(.AMPLITUDE_BITS(AMP_BITS)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_port  (in_ch),
    .out_port (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Predicted generator state.
  logic [PERIOD_W-1:0]      tone_per [NUM_TONE];
  logic [PERIOD_W-1:0]      tone_cnt [NUM_TONE];
  logic                     tone_out [NUM_TONE];
  logic [ATTEN_W-1:0]       tone_att [NUM_TONE];
  logic [PERIOD_W-1:0]      nz_cnt;
  logic [LFSR_W-1:0]        nz_lfsr;
  logic                     nz_phase;
  logic [MODE_W-1:0]        nz_mode;
  logic                     nz_out;
  logic [ATTEN_W-1:0]       nz_att;
  logic [LATCH_W-1:0]       latch_sel;
  logic [TABLE_VALUE_W-1:0] amp_tab [TABLE_DEPTH];
  logic [VOL_W-1:0]         mix_volume;

  logic [SAMPLE_W-1:0] pending_samples[$];
  int                  errors = 0;
  int                  items_sent = 0;
  int                  burst_left = 0;
  int                  idle_cycles = 0;
  bit                  steady_feed = 1'b0;
  bit                  hold_req = 1'b0;

  // Clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // One channel's contribution: amplitude scaled by the volume percentage.
  function automatic int unsigned scaled_level(logic lvl, logic [ATTEN_W-1:0] att,
                                               int unsigned vol);
    int unsigned amp;
    amp = 32'(amp_tab[att]);
    return lvl ? amp * vol / 32'd100 : 32'd0;
  endfunction

  // Advance every channel by one tick and return the mixed sample.
  function automatic logic [SAMPLE_W-1:0] mix_after_tick();
    int unsigned vol;
    int unsigned sum;
    logic        fb;
    vol = 32'((mix_volume > VOL_MAX) ? VOL_MAX : mix_volume);
    sum = 0;
    for (int i = 0; i < NUM_TONE; i++) begin
      if (tone_cnt[i] <= PERIOD_W'(1)) begin
        tone_out[i] = ~tone_out[i];
        tone_cnt[i] = tone_per[i];
      end else begin
        tone_cnt[i] = tone_cnt[i] - PERIOD_W'(1);
      end
      sum += scaled_level(tone_out[i], tone_att[i], vol);
    end
    // Noise timer expiry toggles the phase; a rising phase shifts the register.
    if (nz_cnt <= PERIOD_W'(1)) begin
      nz_phase = ~nz_phase;
      case (noise_rate_t'(nz_mode[1:0]))
        NRATE_16: nz_cnt = NOISE_RELOAD0;
        NRATE_32: nz_cnt = NOISE_RELOAD1;
        NRATE_64: nz_cnt = NOISE_RELOAD2;
        default:  nz_cnt = tone_per[2];
      endcase
      if (nz_phase) begin
        fb = nz_lfsr[0] ^ (nz_mode[2] & nz_lfsr[3]);
        nz_lfsr = {fb, nz_lfsr[LFSR_W-1:1]};
        nz_out = nz_lfsr[0];
      end
    end else begin
      nz_cnt = nz_cnt - PERIOD_W'(1);
    end
    sum += scaled_level(nz_out, nz_att, vol);
    if (sum > 32'h7FFF) sum = 32'h7FFF;
    return sum[SAMPLE_W-1:0];
  endfunction

  // Latch/data byte protocol.
  function automatic void apply_psg_byte(logic [BYTE_W-1:0] b);
    logic [CH_W-1:0] ch;
    if (b[7]) latch_sel = b[6:4];
    ch = latch_sel[2:1];
    if (ch != NOISE_SEL) begin
      if (latch_sel[0] == SEL_ATTEN) tone_att[ch] = b[3:0];
      else if (b[7]) tone_per[ch][3:0] = b[3:0];
      else tone_per[ch][9:4] = b[5:0];
    end else if (latch_sel[0] == SEL_ATTEN) begin
      nz_att = b[3:0];
    end else begin
      nz_mode = b[2:0];
      nz_lfsr = NOISE_SEED;
    end
  endfunction

  function automatic logic [BYTE_W-1:0] latch_byte(logic [CH_W-1:0] ch, logic sel,
                                                   logic [3:0] low);
    return {1'b1, ch, sel, low};
  endfunction

  // Offer one item, in bursts with random gaps, and predict it once accepted.
  task automatic send_item(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data,
                           logic [TABLE_IDX_W-1:0] idx, logic [TABLE_VALUE_W-1:0] val);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 32);
      if (gap > 0 && !steady_feed) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.op          <= op;
    in_ch.data_byte   <= data;
    in_ch.table_index <= idx;
    in_ch.table_value <= val;
    do @(posedge clk); while (!in_ch.ready);
    if (op != OP_UNUSED) items_sent++;
    case (op)
      OP_TICK:       pending_samples.push_back(mix_after_tick());
      OP_REG_WRITE:  apply_psg_byte(data);
      OP_TABLE_LOAD: amp_tab[idx] = TABLE_VALUE_W'(val & ((1 << AMP_BITS) - 1));
      default: ;
    endcase
  endtask

  task automatic send_tick();
    send_item(OP_TICK, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
              13'($urandom_range(0, 8191)));
  endtask

  task automatic send_byte(logic [BYTE_W-1:0] b);
    send_item(OP_REG_WRITE, b, 4'($urandom_range(0, 15)), 13'($urandom_range(0, 8191)));
  endtask

  task automatic send_load(logic [TABLE_IDX_W-1:0] idx, logic [TABLE_VALUE_W-1:0] val);
    send_item(OP_TABLE_LOAD, 8'($urandom_range(0, 255)), idx, val);
  endtask

  // Stop offering and let every sample and any write still in flight finish.
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  task automatic set_volume(logic [VOL_W-1:0] v);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    mix_volume = v;
  endtask

  // Right after reset the table is empty, so ticks are silent; op 3 is ignored.
  task automatic test_reset_silence();
    send_tick();
    send_item(OP_UNUSED, 8'hFF, 4'hF, 13'h1FFF);
    send_tick();
  endtask

  // Table extremes and a set of registers reached by latch and by data bytes.
  task automatic test_register_protocol();
    send_load(4'd0, 13'h1FFF);
    send_load(4'd15, 13'h0000);
    send_load(4'd5, 13'h0AAA);
    send_load(4'd10, 13'h1555);
    send_byte(latch_byte(2'd0, SEL_ATTEN, 4'd0));
    send_byte(latch_byte(2'd1, SEL_ATTEN, 4'd5));
    send_byte(8'h0A);
    send_byte(latch_byte(2'd1, SEL_PERIOD, 4'hF));
    send_byte(8'h7F);
    send_byte(latch_byte(2'd2, SEL_PERIOD, 4'h2));
    send_byte(8'h00);
    send_byte(latch_byte(NOISE_SEL, SEL_ATTEN, 4'd0));
    send_byte(latch_byte(NOISE_SEL, SEL_PERIOD, 4'h7));
    repeat (3) send_tick();
    // A data byte to the noise control also reseeds the shift register.
    send_byte(8'h7C);
    repeat (2) send_tick();
  endtask

  // Zero, the smallest step, the saturated range and the reset value.
  task automatic test_volume_extremes();
    set_volume(7'd0);
    send_tick();
    set_volume(7'd127);
    repeat (2) send_tick();
    set_volume(7'd1);
    send_tick();
    set_volume(VOL_MAX);
  endtask

  // Hold the result side off while ticks keep coming, so the input backs up.
  task automatic test_output_holdoff();
    steady_feed = 1'b1;
    hold_req = 1'b1;
    repeat (40) send_tick();
    steady_feed = 1'b0;
  endtask

  // Mostly well-formed register sequences between runs of ticks, plus noise.
  task automatic test_random_traffic();
    int                target;
    int                next_vol;
    int                pick;
    logic [3:0]        nib;
    logic [5:0]        hi;
    logic [CH_W-1:0]   ch;
    logic [VOL_W-1:0]  vols [8];
    vols = '{7'd0, 7'd1, 7'd50, 7'd99, 7'd100, 7'd101, 7'd127, 7'd73};
    for (int i = 0; i < TABLE_DEPTH; i++)
      send_load(4'(i), 13'($urandom_range(0, 8191)));
    target = items_sent + RANDOM_ITEMS;
    next_vol = items_sent + 150;
    while (items_sent < target) begin
      if (items_sent >= next_vol) begin
        set_volume($urandom_range(0, 3) == 0 ? 7'($urandom_range(0, 127))
                                             : vols[$urandom_range(0, 7)]);
        next_vol = items_sent + $urandom_range(100, 200);
      end
      pick = $urandom_range(0, 99);
      nib = 4'($urandom_range(0, 15));
      if (pick < 35) begin
        repeat ($urandom_range(4, 24)) send_tick();
      end else if (pick < 55) begin
        // Period write; short periods keep the tones toggling.
        ch = 2'($urandom_range(0, 2));
        send_byte(latch_byte(ch, SEL_PERIOD, nib));
        if ($urandom_range(0, 3) != 0) begin
          hi = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'd0;
          send_byte({1'b0, 1'($urandom_range(0, 1)), hi});
        end
      end else if (pick < 70) begin
        ch = 2'($urandom_range(0, 3));
        send_byte(latch_byte(ch, SEL_ATTEN, nib));
        if ($urandom_range(0, 1) == 1)
          send_byte({1'b0, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15))});
      end else if (pick < 80) begin
        send_byte(latch_byte(NOISE_SEL, SEL_PERIOD, nib));
        if ($urandom_range(0, 2) == 0) send_byte(8'($urandom_range(0, 127)));
      end else if (pick < 90) begin
        send_load(nib, 13'($urandom_range(0, 8191)));
      end else if (pick < 97) begin
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_item(OP_UNUSED, 8'($urandom_range(0, 255)), nib,
                  13'($urandom_range(0, 8191)));
      end
    end
  endtask

  // Result side: stall patterns that change now and then, or a long hold-off.
  initial begin : result_stall
    logic [7:0] stall_pat;
    int         span;
    stall_pat = 8'hFF;
    span = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        if (span == 0) begin
          span = $urandom_range(16, 160);
          stall_pat = ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
        end
        span--;
        out_ch.ready <= stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[7:1]};
      end
    end
  end

  // Compare each sample with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected sample, expected none, actual %0d", $time, out_ch.sample);
        errors++;
      end else if (pending_samples[0] !== out_ch.sample) begin
        $display("%0t: sample mismatch, expected %0d, actual %0d", $time,
                 pending_samples[0], out_ch.sample);
        errors++;
        void'(pending_samples.pop_front());
      end else begin
        void'(pending_samples.pop_front());
      end
    end
  end

  // Watchdog on cycles in which neither side moves an item.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Main sequence.
  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.op          = '0;
    in_ch.data_byte   = '0;
    in_ch.table_index = '0;
    in_ch.table_value = '0;
    out_ch.ready      = 1'b0;
    for (int i = 0; i < NUM_TONE; i++) begin
      tone_per[i] = '0;
      tone_cnt[i] = '0;
      tone_out[i] = 1'b0;
      tone_att[i] = ATTEN_RESET;
    end
    nz_cnt     = '0;
    nz_lfsr    = NOISE_SEED;
    nz_phase   = 1'b0;
    nz_mode    = '0;
    nz_out     = 1'b0;
    nz_att     = ATTEN_RESET;
    latch_sel  = '0;
    mix_volume = VOL_RESET;
    for (int i = 0; i < TABLE_DEPTH; i++) amp_tab[i] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_silence();
    test_register_protocol();
    test_volume_extremes();
    test_output_holdoff();
    test_random_traffic();
    wait_idle();

    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
